>>> hdl/ddo_pkg.sv
// Shared types, constants and the arctangent table of the odometry block.
package ddo_pkg;

    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int CORDIC_MAX_ITER = 30;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_POS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_NEG    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_POS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_NEG   = 3'd6;

    // Multiplier: 48 x 32 bit magnitudes, formed from two 24-bit slices.
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_SLICE_W = 24;

    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;

    localparam int TRIG_W = 34;
    localparam int ANG_W = 22;

    localparam logic [31:0] PI_Q20 = 32'd3294199;
    localparam logic [63:0] LIN_HALF = 64'd1000 << 20;

    // The rounded division by 2000 * 2^20 drops the low 24 bits first, then
    // multiplies by the reciprocal of 125 and keeps bits 39 and up. This is
    // exact for any 32-bit value left after the shift.
    localparam logic [32:0] LIN_RECIP = 33'd4398046512;
    localparam int LIN_PRE_SH = 24;
    localparam int LIN_RECIP_SH = 39;

    localparam logic signed [ANG_W-1:0] PI_Q16      = 22'sd205887;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 22'sd102944;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q16  = 22'sd411775;
    localparam logic signed [TRIG_W-1:0] CORDIC_K_Q30 = 34'sd652032874;

    typedef enum logic [3:0] {
        OP_DP, OP_VN, OP_VDIV, OP_VGAIN, OP_WDT, OP_WN, OP_WDIV,
        OP_WWT, OP_WGAIN, OP_PDT, OP_DX, OP_DY
    } op_t;

    function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [TRIG_W-1:0] a;
        case (i)
            5'd0:    a = 34'sd843314857;
            5'd1:    a = 34'sd497837829;
            5'd2:    a = 34'sd263043837;
            5'd3:    a = 34'sd133525159;
            5'd4:    a = 34'sd67021687;
            5'd5:    a = 34'sd33543516;
            5'd6:    a = 34'sd16775851;
            5'd7:    a = 34'sd8388437;
            5'd8:    a = 34'sd4194283;
            5'd9:    a = 34'sd2097149;
            5'd10:   a = 34'sd1048576;
            default: a = 34'sd1 <<< (5'd30 - i);
        endcase
        return a;
    endfunction

endpackage

>>> hdl/ddo_mul.sv
// Shared unsigned multiplier, 48 x 32 bits in two 24-bit slice passes.
module ddo_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ddo_pkg::MUL_A_W-1:0]  a,
    input  logic [ddo_pkg::MUL_B_W-1:0]  b,
    output logic                         done,
    output logic [ddo_pkg::MUL_P_W-1:0]  prod
);
    import ddo_pkg::*;

    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [MUL_P_W-1:0] acc_reg;
    logic busy_reg, high_reg, done_reg;
    logic [MUL_SLICE_W-1:0] slice;
    logic [MUL_SLICE_W+MUL_B_W-1:0] pp;

    assign slice = high_reg ? a_reg[MUL_A_W-1:MUL_SLICE_W] : a_reg[MUL_SLICE_W-1:0];
    assign pp = slice * b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            high_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                high_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (high_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                high_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            if (high_reg)
                acc_reg <= acc_reg + (MUL_P_W'(pp) << MUL_SLICE_W);
            else
                acc_reg <= MUL_P_W'(pp);
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> hdl/ddo_div.sv
// Restoring divider, one quotient bit per cycle.
module ddo_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ddo_pkg::DIV_N_W-1:0]  num,
    input  logic [ddo_pkg::DIV_D_W-1:0]  den,
    output logic                         done,
    output logic [ddo_pkg::DIV_N_W-1:0]  quo
);
    import ddo_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_N_W-1:0] nq_reg;
    logic [DIV_D_W-1:0] den_reg, rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [DIV_D_W:0] rem_sh, rem_sub;
    logic fits;

    assign rem_sh = {rem_reg, nq_reg[DIV_N_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // The numerator shifts out at the top while quotient bits enter below.
            nq_reg <= {nq_reg[DIV_N_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo = nq_reg;

endmodule

>>> hdl/ddo_cordic.sv
// Iterative rotation CORDIC giving cosine and sine of the heading in Q30.
module ddo_cordic #(
    parameter int TRIG_ITERATIONS = ddo_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [19:0]                 angle,
    output logic                               valid,
    output logic signed [ddo_pkg::TRIG_W-1:0]  cos_out,
    output logic signed [ddo_pkg::TRIG_W-1:0]  sin_out
);
    import ddo_pkg::*;

    localparam int N_IT = (TRIG_ITERATIONS > CORDIC_MAX_ITER) ? CORDIC_MAX_ITER
                                                              : TRIG_ITERATIONS;
    localparam int CNT_W = $clog2(N_IT + 1);

    logic signed [TRIG_W-1:0] x_reg, y_reg, z_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic busy_reg, valid_reg, neg_reg;
    logic signed [ANG_W-1:0] a0, a1, a2, a3;
    logic half;
    logic signed [TRIG_W-1:0] z_init, dx, dy, at;

    always_comb
    begin
        a0 = {{2{angle[19]}}, angle};
        a1 = a0;
        if (a1 > PI_Q16)
            a1 = a1 - TWO_PI_Q16;
        if (a1 < -PI_Q16)
            a1 = a1 + TWO_PI_Q16;
        a2 = a1;
        if (a2 > PI_Q16)
            a2 = a2 - TWO_PI_Q16;
        if (a2 < -PI_Q16)
            a2 = a2 + TWO_PI_Q16;
        // A half turn brings the angle into the converging range; both outputs flip.
        half = 1'b0;
        a3 = a2;
        if (a2 > HALF_PI_Q16)
        begin
            a3 = a2 - PI_Q16;
            half = 1'b1;
        end
        else if (a2 < -HALF_PI_Q16)
        begin
            a3 = a2 + PI_Q16;
            half = 1'b1;
        end
        z_init = {{(TRIG_W-ANG_W){a3[ANG_W-1]}}, a3} <<< 14;
    end

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign at = atan_q30(5'(cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                valid_reg <= 1'b0;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(N_IT))
                begin
                    busy_reg <= 1'b0;
                    valid_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_K_Q30;
            y_reg <= '0;
            z_reg <= z_init;
            neg_reg <= half;
        end
        else if (busy_reg && cnt_reg != CNT_W'(N_IT))
        begin
            if (!z_reg[TRIG_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign valid = valid_reg;
    assign cos_out = neg_reg ? -x_reg : x_reg;
    assign sin_out = neg_reg ? -y_reg : y_reg;

endmodule

>>> hdl/diff_drive_odometry.sv
// Differential-drive odometry: sequencer around a shared multiplier and divider.
//
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall  | left_rev_rate, right_rev_rate, time_step
//  out     | out       | out_valid/out_stall| pos_x, pos_y, heading, linear_speed,
//          |           |                    | heading_increment
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// One item runs in turn on the shared units: eleven two-pass multiplications
// (issue, two slice passes, completion each), one division for the turn, and a
// step each to accept and to finish. The CORDIC runs alongside from acceptance
// and is long finished when needed. Reset clears the pose and loads the defaults.
// While a result waits under out_stall the next item is accepted and worked on;
// it waits at its end until the output register is free.
module diff_drive_odometry #(
    parameter int TRIG_ITERATIONS = ddo_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [23:0]                 left_rev_rate,
    input  logic signed [23:0]                 right_rev_rate,
    input  logic [19:0]                        time_step,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [31:0]                 pos_x,
    output logic signed [31:0]                 pos_y,
    output logic signed [19:0]                 heading,
    output logic signed [23:0]                 linear_speed,
    output logic signed [19:0]                 heading_increment,
    input  logic                               cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ddo_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg;
    op_t op_reg;

    logic [9:0]  dia_reg;
    logic [11:0] sep_reg;
    logic [16:0] weight_reg;
    logic [17:0] lin_pos_reg, lin_neg_reg, turn_pos_reg, turn_neg_reg;

    logic signed [31:0] x_acc_reg, y_acc_reg;
    logic signed [19:0] heading_reg;
    logic signed [23:0] speed_out_reg;
    logic signed [19:0] incr_out_reg;
    logic out_valid_reg;

    logic [24:0] sum_mag_reg, dif_mag_reg;
    logic sum_neg_reg, dif_neg_reg;
    logic [19:0] dt_reg;
    logic [31:0] dp_reg;
    logic [63:0] wide_reg;
    logic signed [23:0] v_reg;
    logic signed [19:0] w_reg;
    logic [27:0] pmag_reg;
    logic p_neg_reg;
    logic signed [30:0] dx_reg, dy_reg;

    logic accept;
    logic signed [24:0] sum_in, dif_in;
    logic [11:0] sep_eff;
    logic [63:0] v_rnd;

    logic mul_start, mul_done, div_start, div_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod, r16, r30;
    logic [DIV_N_W-1:0] div_num, div_quo;
    logic [DIV_D_W-1:0] div_den;
    logic is_div, unit_done;

    logic cordic_valid;
    logic signed [TRIG_W-1:0] cos_v, sin_v;
    logic [TRIG_W-1:0] cos_mag, sin_mag;
    logic [23:0] v_abs;

    logic signed [23:0] v_sat;
    logic signed [19:0] w_sat;
    logic [30:0] d_mag;
    logic signed [30:0] d_signed;
    logic signed [32:0] x_sum, y_sum;
    logic signed [31:0] x_new, y_new;
    logic signed [20:0] t_sum;
    logic signed [19:0] h_new;
    logic out_free;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign sum_in = 25'(left_rev_rate) + 25'(right_rev_rate);
    assign dif_in = 25'(right_rev_rate) - 25'(left_rev_rate);
    assign sep_eff = (sep_reg == '0) ? 12'd1 : sep_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign v_rnd = wide_reg + LIN_HALF;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dia_reg <= 10'd100;
            sep_reg <= 12'd200;
            weight_reg <= 17'd65536;
            lin_pos_reg <= 18'd65536;
            lin_neg_reg <= 18'd65536;
            turn_pos_reg <= 18'd65536;
            turn_neg_reg <= 18'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIAMETER:   dia_reg <= cfg_data[9:0];
                CFG_SEPARATION: sep_reg <= cfg_data[11:0];
                CFG_WEIGHT:     weight_reg <= cfg_data[16:0];
                CFG_LIN_POS:    lin_pos_reg <= cfg_data;
                CFG_LIN_NEG:    lin_neg_reg <= cfg_data;
                CFG_TURN_POS:   turn_pos_reg <= cfg_data;
                CFG_TURN_NEG:   turn_neg_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cos_mag = cos_v[TRIG_W-1] ? TRIG_W'(-cos_v) : TRIG_W'(cos_v);
    assign sin_mag = sin_v[TRIG_W-1] ? TRIG_W'(-sin_v) : TRIG_W'(sin_v);
    assign v_abs = v_reg[23] ? 24'(-v_reg) : 24'(v_reg);

    // Operand selection for the shared units
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        div_num = wide_reg;
        div_den = '0;
        is_div = 1'b0;
        unique case (op_reg)
            OP_DP:
            begin
                mul_a = MUL_A_W'(dia_reg);
                mul_b = PI_Q20;
            end
            OP_VN:
            begin
                mul_a = MUL_A_W'(sum_mag_reg);
                mul_b = dp_reg;
            end
            OP_VDIV:
            begin
                mul_a = MUL_A_W'(LIN_RECIP);
                mul_b = v_rnd[LIN_PRE_SH+MUL_B_W-1:LIN_PRE_SH];
            end
            OP_VGAIN:
            begin
                mul_a = wide_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(sum_neg_reg ? lin_neg_reg : lin_pos_reg);
            end
            OP_WDT:
            begin
                mul_a = MUL_A_W'(dif_mag_reg);
                mul_b = MUL_B_W'(dt_reg);
            end
            OP_WN:
            begin
                mul_a = wide_reg[MUL_A_W-1:0];
                mul_b = dp_reg;
            end
            OP_WDIV:
            begin
                is_div = 1'b1;
                div_num = wide_reg + (DIV_N_W'(sep_eff) << 19);
                div_den = DIV_D_W'(sep_eff) << 20;
            end
            OP_WWT:
            begin
                mul_a = wide_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(weight_reg);
            end
            OP_WGAIN:
            begin
                mul_a = wide_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(dif_neg_reg ? turn_neg_reg : turn_pos_reg);
            end
            OP_PDT:
            begin
                mul_a = MUL_A_W'(v_abs);
                mul_b = MUL_B_W'(dt_reg);
            end
            OP_DX:
            begin
                mul_a = MUL_A_W'(pmag_reg);
                mul_b = cos_mag[MUL_B_W-1:0];
            end
            OP_DY:
            begin
                mul_a = MUL_A_W'(pmag_reg);
                mul_b = sin_mag[MUL_B_W-1:0];
            end
            default: ;
        endcase
    end

    // The trig results must be ready before the position products start.
    assign mul_start = (state_reg == ST_ISSUE) && !is_div
                       && (cordic_valid || (op_reg != OP_DX && op_reg != OP_DY));
    assign div_start = (state_reg == ST_ISSUE) && is_div;
    assign unit_done = is_div ? div_done : mul_done;

    ddo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ddo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    ddo_cordic #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .angle   (heading_reg),
        .valid   (cordic_valid),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    // Rounded magnitudes, ties away from zero since the sign is held apart.
    assign r16 = (mul_prod + (MUL_P_W'(1) << 15)) >> 16;
    assign r30 = (mul_prod + (MUL_P_W'(1) << 29)) >> 30;

    always_comb
    begin
        if (sum_neg_reg)
            v_sat = (r16 >= MUL_P_W'(24'h800000)) ? 24'sh800000 : -$signed(24'(r16));
        else
            v_sat = (r16 > MUL_P_W'(24'h7FFFFF)) ? 24'sh7FFFFF : $signed(24'(r16));
        if (dif_neg_reg)
            w_sat = (r16 >= MUL_P_W'(20'h80000)) ? 20'sh80000 : -$signed(20'(r16));
        else
            w_sat = (r16 > MUL_P_W'(20'h7FFFF)) ? 20'sh7FFFF : $signed(20'(r16));
        d_mag = r30[30:0];
        if (p_neg_reg ^ ((op_reg == OP_DX) ? cos_v[TRIG_W-1] : sin_v[TRIG_W-1]))
            d_signed = -$signed(d_mag);
        else
            d_signed = $signed(d_mag);
    end

    always_comb
    begin
        x_sum = 33'(x_acc_reg) + 33'(dx_reg);
        y_sum = 33'(y_acc_reg) + 33'(dy_reg);
        if (x_sum > 33'sh07FFFFFFF)
            x_new = 32'sh7FFFFFFF;
        else if (x_sum < -33'sh080000000)
            x_new = 32'sh80000000;
        else
            x_new = 32'(x_sum);
        if (y_sum > 33'sh07FFFFFFF)
            y_new = 32'sh7FFFFFFF;
        else if (y_sum < -33'sh080000000)
            y_new = 32'sh80000000;
        else
            y_new = 32'(y_sum);
        // Fold once by a whole turn in either direction, then clip.
        t_sum = 21'(heading_reg) + 21'(w_reg);
        if (t_sum >= 21'(TWO_PI_Q16))
            t_sum = t_sum - 21'(TWO_PI_Q16);
        if (t_sum <= -21'(TWO_PI_Q16))
            t_sum = t_sum + 21'(TWO_PI_Q16);
        if (t_sum > 21'sh7FFFF)
            h_new = 20'sh7FFFF;
        else if (t_sum < -21'sh80000)
            h_new = 20'sh80000;
        else
            h_new = 20'(t_sum);
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_DP;
            out_valid_reg <= 1'b0;
            x_acc_reg <= '0;
            y_acc_reg <= '0;
            heading_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg <= OP_DP;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    if (mul_start || div_start)
                        state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (unit_done)
                    begin
                        if (op_reg == OP_DY)
                            state_reg <= ST_FIN;
                        else
                        begin
                            op_reg <= op_t'(op_reg + 1'b1);
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        x_acc_reg <= x_new;
                        y_acc_reg <= y_new;
                        heading_reg <= h_new;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_neg_reg <= sum_in[24];
            sum_mag_reg <= sum_in[24] ? 25'(-sum_in) : 25'(sum_in);
            dif_neg_reg <= dif_in[24];
            dif_mag_reg <= dif_in[24] ? 25'(-dif_in) : 25'(dif_in);
            dt_reg <= time_step;
        end
        if (state_reg == ST_WAIT && unit_done)
        begin
            case (op_reg)
                OP_DP:
                    dp_reg <= mul_prod[31:0];
                OP_VN, OP_WN:
                    wide_reg <= mul_prod[63:0];
                OP_VDIV:
                    wide_reg <= 64'(mul_prod >> LIN_RECIP_SH);
                OP_WDIV:
                    wide_reg <= div_quo;
                OP_VGAIN:
                    v_reg <= v_sat;
                OP_WDT, OP_WWT:
                    wide_reg <= r16[63:0];
                OP_WGAIN:
                    w_reg <= w_sat;
                OP_PDT:
                begin
                    pmag_reg <= r16[27:0];
                    p_neg_reg <= v_reg[23];
                end
                OP_DX:
                    dx_reg <= d_signed;
                OP_DY:
                    dy_reg <= d_signed;
                default: ;
            endcase
        end
        if (state_reg == ST_FIN && out_free)
        begin
            speed_out_reg <= v_reg;
            incr_out_reg <= w_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x = x_acc_reg;
    assign pos_y = y_acc_reg;
    assign heading = heading_reg;
    assign linear_speed = speed_out_reg;
    assign heading_increment = incr_out_reg;

endmodule
